### hw/rtl/bmtc_pkg.sv
// Shared constants, codes and helper functions for the bitmap text cursor renderer.
// No dependencies; imported by the top level and the checker.
package bmtc_pkg;

	// Glyph memory size and record layout limits.
	localparam int GLYPH_MEM_DEPTH = 2048;
	localparam int MAX_STRIDE      = 16;
	localparam int MEM_AW          = $clog2(GLYPH_MEM_DEPTH);
	// Width of a glyph lookup address: it covers 95 records of at most MAX_STRIDE bytes.
	localparam int GA_W            = $clog2(95 * MAX_STRIDE);
	localparam int SW              = $clog2(MAX_STRIDE + 1);
	localparam int COL_LIMIT       = (MAX_STRIDE - 1) < 15 ? (MAX_STRIDE - 1) : 15;
	localparam int CW              = 4;

	// Command codes.
	localparam logic [1:0] CMD_SET  = 2'd0;
	localparam logic [1:0] CMD_PUT  = 2'd1;
	localparam logic [1:0] CMD_LOAD = 2'd2;

	// Result kinds.
	localparam logic KIND_COL   = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// Configuration register indexes.
	localparam logic REG_STRIDE = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Character codes with special handling.
	localparam logic [7:0] CH_FIRST = 8'h20;
	localparam logic [7:0] CH_LAST  = 8'h7E;
	localparam logic [7:0] CH_BELL  = 8'h07;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;

	// Stride clamped to 1..MAX_STRIDE.
	function automatic logic [SW-1:0] eff_stride(input logic [4:0] s);
		logic [SW-1:0] r;
		if (s == 5'd0) begin
			r = SW'(1);
		end else if (32'(s) > MAX_STRIDE) begin
			r = SW'(MAX_STRIDE);
		end else begin
			r = SW'(s);
		end
		return r;
	endfunction

	// Row height clamped to 1..8.
	function automatic logic [3:0] eff_height(input logic [3:0] h);
		logic [3:0] r;
		if (h == 4'd0) begin
			r = 4'd1;
		end else if (h > 4'd8) begin
			r = 4'd8;
		end else begin
			r = h;
		end
		return r;
	endfunction

	// Mask with the low h bits set, for h in 1..8.
	function automatic logic [7:0] height_mask(input logic [3:0] h);
		logic [8:0] m;
		m = (9'd1 << h) - 9'd1;
		return m[7:0];
	endfunction

	// Glyph width byte saturated to the column limit.
	function automatic logic [CW-1:0] sat_width(input logic [7:0] w);
		logic [CW-1:0] r;
		if (32'(w) > COL_LIMIT) begin
			r = CW'(COL_LIMIT);
		end else begin
			r = w[CW-1:0];
		end
		return r;
	endfunction

endpackage

### hw/rtl/bmtc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the glyph memory.
module bmtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/bitmap_text_cursor_renderer_top.sv
// A printable character reads its width byte and then one glyph memory byte per column, and
// gives its columns one per cycle while the output register is free. The next request is taken
// only once a printable one has finished, and a stalled result holds off new requests. Reset
// (arst_n low) clears the cursor, the last width and the handshake state and restores stride 6
// and row height 8.
// Top level around the glyph memory, which reset leaves as it is. Uses bmtc_pkg, bmtc_ram.
module bitmap_text_cursor_renderer_top
	import bmtc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_wdata,
	// Request channel.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic [7:0]  ink,
	input  logic [7:0]  char_code,
	input  logic [10:0] mem_addr,
	input  logic [7:0]  mem_byte,
	// Result channel.
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  col_x,
	output logic [7:0]  top_y,
	output logic [7:0]  pixel_mask,
	output logic [7:0]  out_ink,
	output logic        last
);

	typedef enum logic [1:0] {S_IDLE, S_WADDR, S_WDATA, S_COL} state_t;

	state_t          state_q;
	logic [4:0]      stride_q;
	logic [3:0]      height_q;
	logic [7:0]      cursor_x_q;
	logic [7:0]      cursor_y_q;
	logic [CW-1:0]   last_w_q;
	logic [GA_W-1:0] base_q;
	logic [CW-1:0]   w_q;
	logic [CW-1:0]   k_q;
	logic [7:0]      ink_q;
	logic            rd_oor_q;

	logic            out_valid_q;
	logic            kind_q;
	logic [7:0]      col_x_q;
	logic [7:0]      top_y_q;
	logic [7:0]      mask_q;
	logic [7:0]      out_ink_q;
	logic            last_q;

	logic            out_free;
	logic            accept;
	logic [6:0]      ch_off;
	logic [GA_W-1:0] base_prod;
	logic [3:0]      h_eff;
	logic            printable;

	logic            ram_we;
	logic [MEM_AW-1:0] ram_waddr;
	logic            ram_re;
	logic [GA_W-1:0] rd_addr;
	logic [MEM_AW-1:0] ram_raddr;
	logic [7:0]      ram_rdata;
	logic [7:0]      mem_data;
	logic [CW-1:0]   k_next;
	logic [CW-1:0]   w_read;

	// Handshake: the output register is free when empty or being drained.
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	// Record base address of a printable character.
	assign ch_off    = 7'(char_code - CH_FIRST);
	assign base_prod = GA_W'(ch_off) * GA_W'(eff_stride(stride_q));
	assign h_eff     = eff_height(height_q);
	assign printable = (char_code >= CH_FIRST) && (char_code <= CH_LAST);

	// Glyph memory load port, only for addresses inside the memory.
	assign ram_we    = accept && (cmd == CMD_LOAD) && (32'(mem_addr) < GLYPH_MEM_DEPTH);
	assign ram_waddr = MEM_AW'(mem_addr);

	// Read side: width byte first, then one column byte per cycle while the output register is free.
	assign mem_data = rd_oor_q ? 8'd0 : ram_rdata;
	assign w_read   = sat_width(mem_data);
	assign k_next   = (state_q == S_COL) ? k_q + CW'(1) : '0;

	always_comb begin
		ram_re  = 1'b0;
		rd_addr = base_q;
		unique case (state_q)
			S_WADDR: begin
				ram_re  = 1'b1;
				rd_addr = base_q;
			end
			S_WDATA: begin
				ram_re  = (w_read != '0);
				rd_addr = base_q + GA_W'(1) + GA_W'(k_next);
			end
			S_COL: begin
				ram_re  = out_free && (k_q + CW'(1) != w_q);
				rd_addr = base_q + GA_W'(1) + GA_W'(k_next);
			end
			S_IDLE: begin
				ram_re  = 1'b0;
				rd_addr = base_q;
			end
		endcase
	end

	assign ram_raddr = MEM_AW'(rd_addr);

	bmtc_ram #(
		.WIDTH(8),
		.DEPTH(GLYPH_MEM_DEPTH)
	) u_glyph_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (mem_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Control state machine, cursor state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stride_q    <= 5'd6;
			height_q    <= 4'd8;
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
			last_w_q    <= '0;
			base_q      <= '0;
			w_q         <= '0;
			k_q         <= '0;
			ink_q       <= '0;
			rd_oor_q    <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_COL;
			col_x_q     <= '0;
			top_y_q     <= '0;
			mask_q      <= '0;
			out_ink_q   <= '0;
			last_q      <= 1'b0;
		end else begin
			// Configuration writes.
			if (cfg_wen) begin
				unique case (cfg_index)
					REG_STRIDE: stride_q <= cfg_wdata;
					REG_HEIGHT: height_q <= cfg_wdata[3:0];
				endcase
			end

			// Track whether the read in flight falls outside the memory.
			if (ram_re) begin
				rd_oor_q <= !(32'(rd_addr) < GLYPH_MEM_DEPTH);
			end

			// Drain the output register; a new result below takes precedence.
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (cmd)
							CMD_SET: begin
								cursor_x_q <= pos_x;
								cursor_y_q <= pos_y;
								last_w_q   <= '0;
							end
							CMD_PUT: begin
								if (printable) begin
									base_q  <= base_prod;
									ink_q   <= ink;
									state_q <= S_WADDR;
								end else if (char_code == CH_BELL) begin
									cursor_x_q <= '0;
									cursor_y_q <= '0;
								end else if (char_code == CH_FF) begin
									cursor_x_q  <= '0;
									cursor_y_q  <= '0;
									out_valid_q <= 1'b1;
									kind_q      <= KIND_CLEAR;
									col_x_q     <= '0;
									top_y_q     <= '0;
									mask_q      <= '0;
									out_ink_q   <= '0;
									last_q      <= 1'b1;
								end else if (char_code == CH_LF) begin
									cursor_x_q <= '0;
									cursor_y_q <= cursor_y_q + 8'(h_eff);
									last_w_q   <= '0;
								end else if (char_code == CH_BS) begin
									cursor_x_q <= cursor_x_q - 8'(last_w_q) - 8'd1;
									last_w_q   <= '0;
								end
							end
							default: begin
								// Loads are handled by the write port; other codes do nothing.
							end
						endcase
					end
				end
				S_WADDR: begin
					state_q <= S_WDATA;
				end
				S_WDATA: begin
					// Width byte is here: an empty glyph only advances the cursor and clears the last width.
					if (w_read == '0) begin
						cursor_x_q <= cursor_x_q + 8'd1;
						last_w_q   <= '0;
						state_q    <= S_IDLE;
					end else begin
						w_q     <= w_read;
						k_q     <= '0;
						state_q <= S_COL;
					end
				end
				S_COL: begin
					// Emit one column per cycle when the output register can take it.
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_COL;
						col_x_q     <= cursor_x_q + 8'(k_q);
						top_y_q     <= cursor_y_q;
						mask_q      <= mem_data & height_mask(h_eff);
						out_ink_q   <= ink_q;
						last_q      <= (k_q + CW'(1) == w_q);
						k_q         <= k_q + CW'(1);
						if (k_q + CW'(1) == w_q) begin
							cursor_x_q <= cursor_x_q + 8'(w_q) + 8'd1;
							last_w_q   <= w_q;
							state_q    <= S_IDLE;
						end
					end
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign col_x      = col_x_q;
	assign top_y      = top_y_q;
	assign pixel_mask = mask_q;
	assign out_ink    = out_ink_q;
	assign last       = last_q;

endmodule

### hw/rtl/bmtc_checker.sv
// Port-level checks for the bitmap text cursor renderer, bound to the top level.
// Depends on bmtc_pkg and bitmap_text_cursor_renderer_top.
module bmtc_checker
	import bmtc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       kind,
	input logic [7:0] col_x,
	input logic [7:0] top_y,
	input logic [7:0] pixel_mask,
	input logic [7:0] out_ink,
	input logic       last
);

	// A clear request is always marked as the final result of its request.
	a_clear_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_CLEAR) |-> last)
		else $error("clear request without last");

	// A clear request carries all-zero fields.
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_CLEAR) |->
		(col_x == 8'd0) && (top_y == 8'd0) && (pixel_mask == 8'd0) && (out_ink == 8'd0))
		else $error("clear request with nonzero fields");

	// Columns of one glyph advance by one, on the same row, with the same ink.
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (kind == KIND_COL) && !last ##1 out_valid |->
		(kind == KIND_COL) && (col_x == $past(col_x) + 8'd1) &&
		(top_y == $past(top_y)) && (out_ink == $past(out_ink)))
		else $error("glyph columns out of sequence");

	// A stalled result holds its column, its mask and its last flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(col_x) && $stable(pixel_mask) &&
		$stable(last))
		else $error("stalled result changed");

	// No request is taken while a result is stalled.
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && out_valid && !out_ready |-> !in_ready)
		else $error("request taken while a result was stalled");

endmodule

bind bitmap_text_cursor_renderer_top bmtc_checker u_bmtc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.kind       (kind),
	.col_x      (col_x),
	.top_y      (top_y),
	.pixel_mask (pixel_mask),
	.out_ink    (out_ink),
	.last       (last)
);

### dv/bmtc_render_checker.sv
// Result checker for the bitmap text cursor renderer: mirrors the cursor, glyph memory and
// registers, predicts column writes and clear requests, and compares them with the outputs.
// Depends on bmtc_pkg; instantiated beside the block by bitmap_text_cursor_renderer_top_test.
module bmtc_render_checker
	import bmtc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic [7:0]  ink,
	input  logic [7:0]  char_code,
	input  logic [10:0] mem_addr,
	input  logic [7:0]  mem_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        kind,
	input  logic [7:0]  col_x,
	input  logic [7:0]  top_y,
	input  logic [7:0]  pixel_mask,
	input  logic [7:0]  out_ink,
	input  logic        last,
	output int          pending,
	output int          fails
);

	typedef struct packed {
		logic       kind;
		logic [7:0] col_x;
		logic [7:0] top_y;
		logic [7:0] pixel_mask;
		logic [7:0] out_ink;
		logic       last;
	} draw_op_t;

	draw_op_t   queued_draws[$];
	logic [7:0] glyph_bytes[GLYPH_MEM_DEPTH];
	logic [7:0] cur_x;
	logic [7:0] cur_y;
	logic [7:0] prev_width;
	logic [4:0] stride_reg;
	logic [3:0] height_reg;

	initial begin
		pending = 0;
		fails = 0;
	end

	// Glyph lookups past the end of the memory read as zero.
	function automatic logic [7:0] glyph_byte(input int addr);
		return (addr < GLYPH_MEM_DEPTH) ? glyph_bytes[addr] : 8'h00;
	endfunction

	// Work out the draws caused by one accepted request and move the cursor.
	task automatic render_request(input logic [1:0] op, input logic [7:0] px, input logic [7:0] py,
			input logic [7:0] pen, input logic [7:0] ch, input logic [10:0] addr,
			input logic [7:0] data);
		int       stride;
		int       height;
		int       base;
		int       width;
		logic [7:0] rows;
		draw_op_t draw;
		stride = (stride_reg == 5'd0) ? 1 : ((int'(stride_reg) > MAX_STRIDE) ? MAX_STRIDE
			: int'(stride_reg));
		height = (height_reg == 4'd0) ? 1 : ((height_reg > 4'd8) ? 8 : int'(height_reg));
		rows = 8'((1 << height) - 1);
		draw = '0;
		case (op)
			CMD_SET: begin
				cur_x = px;
				cur_y = py;
				prev_width = 8'd0;
			end
			CMD_LOAD: begin
				if (int'(addr) < GLYPH_MEM_DEPTH) begin
					glyph_bytes[addr] = data;
				end
			end
			CMD_PUT: begin
				if (ch >= CH_FIRST && ch <= CH_LAST) begin
					// Printable: one column write per glyph column, then advance past a gap.
					base = (int'(ch) - int'(CH_FIRST)) * stride;
					width = int'(glyph_byte(base));
					if (width > COL_LIMIT) begin
						width = COL_LIMIT;
					end
					for (int k = 0; k < width; k++) begin
						draw.kind = KIND_COL;
						draw.col_x = cur_x + 8'(k);
						draw.top_y = cur_y;
						draw.pixel_mask = glyph_byte(base + 1 + k) & rows;
						draw.out_ink = pen;
						draw.last = (k == width - 1);
						queued_draws.push_back(draw);
					end
					prev_width = 8'(width);
					cur_x = cur_x + 8'(width) + 8'd1;
				end else begin
					case (ch)
						CH_BELL: begin
							cur_x = 8'd0;
							cur_y = 8'd0;
						end
						CH_FF: begin
							draw.kind = KIND_CLEAR;
							draw.last = 1'b1;
							queued_draws.push_back(draw);
							cur_x = 8'd0;
							cur_y = 8'd0;
						end
						CH_LF: begin
							cur_x = 8'd0;
							cur_y = cur_y + 8'(height);
							prev_width = 8'd0;
						end
						CH_BS: begin
							cur_x = cur_x - prev_width - 8'd1;
							prev_width = 8'd0;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			fails++;
		end
	endtask

	// Match one accepted result against the oldest predicted draw.
	task automatic check_draw_op();
		draw_op_t want;
		if (queued_draws.size() == 0) begin
			$display("%0t: result with nothing expected: kind %0h col_x %0h top_y %0h mask %0h ink %0h last %0h",
				$time, kind, col_x, top_y, pixel_mask, out_ink, last);
			fails++;
		end else begin
			want = queued_draws.pop_front();
			compare_field("kind", 8'(want.kind), 8'(kind));
			compare_field("col_x", want.col_x, col_x);
			compare_field("top_y", want.top_y, top_y);
			compare_field("pixel_mask", want.pixel_mask, pixel_mask);
			compare_field("out_ink", want.out_ink, out_ink);
			compare_field("last", 8'(want.last), 8'(last));
		end
	endtask

	// Follow register writes, requests and results on each clock edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x = 8'd0;
			cur_y = 8'd0;
			prev_width = 8'd0;
			stride_reg = 5'd6;
			height_reg = 4'd8;
			queued_draws.delete();
		end else begin
			if (cfg_wen) begin
				if (cfg_index == REG_STRIDE) begin
					stride_reg = cfg_wdata;
				end else begin
					height_reg = cfg_wdata[3:0];
				end
			end
			if (in_valid && in_ready) begin
				render_request(cmd, pos_x, pos_y, ink, char_code, mem_addr, mem_byte);
			end
			if (out_valid && out_ready) begin
				check_draw_op();
			end
		end
		pending = queued_draws.size();
	end

endmodule

### dv/bitmap_text_cursor_renderer_top_test.sv
// Testbench for bitmap_text_cursor_renderer_top: fills the glyph records it uses, runs directed
// and random text with random handshake gaps over several stride and row height settings.
// Depends on bmtc_pkg, the block's RTL and bmtc_render_checker, which compares every result.
module bitmap_text_cursor_renderer_top_test;
	import bmtc_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam logic [7:0] CH_WIDE  = 8'h21;
	localparam logic [7:0] CH_EMPTY = 8'h22;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 20;
	// Slowest correct stretch is the long result hold plus one glyph and two gaps.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 18;
	// Characters used for text; their records stay inside the filled area at any stride.
	localparam int ALPHA_N        = 6;
	localparam int FILL_BYTES     = ALPHA_N * MAX_STRIDE;
	// Register settings, listed from the last phase to the first.
	localparam logic [PHASES-1:0][4:0] STRIDE_SET = {5'd9, 5'd3, 5'd17, 5'd31, 5'd16, 5'd1,
		5'd0, 5'd6};
	localparam logic [PHASES-1:0][3:0] HEIGHT_SET = {4'd2, 4'd8, 4'd4, 4'd9, 4'd15, 4'd1,
		4'd0, 4'd8};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic        cfg_index = REG_STRIDE;
	logic [4:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_SET;
	logic [7:0]  pos_x = '0;
	logic [7:0]  pos_y = '0;
	logic [7:0]  ink = '0;
	logic [7:0]  char_code = '0;
	logic [10:0] mem_addr = '0;
	logic [7:0]  mem_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [7:0]  col_x;
	logic [7:0]  top_y;
	logic [7:0]  pixel_mask;
	logic [7:0]  out_ink;
	logic        last;
	int          pending;
	int          fails;
	bit          no_idle = 1'b0;
	bit          long_hold = 1'b0;
	bit          hold_done = 1'b0;
	int          quiet_cycles = 0;

	bitmap_text_cursor_renderer_top dut (.*);
	bmtc_render_checker draw_check (.*);

	always #5 clk = ~clk;

	// Offer one request after a random gap (none while no_idle is set) and hold it until it is taken.
	task automatic send_req(input logic [1:0] op, input logic [7:0] px, input logic [7:0] py,
			input logic [7:0] pen, input logic [7:0] ch, input logic [10:0] addr,
			input logic [7:0] data);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		pos_x <= px;
		pos_y <= py;
		ink <= pen;
		char_code <= ch;
		mem_addr <= addr;
		mem_byte <= data;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic put_char(input logic [7:0] ch, input logic [7:0] pen);
		send_req(CMD_PUT, 8'($urandom), 8'($urandom), pen, ch, 11'($urandom), 8'($urandom));
	endtask

	task automatic load_byte(input int addr, input logic [7:0] data);
		send_req(CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 11'(addr),
			data);
	endtask

	task automatic set_cursor(input logic [7:0] px, input logic [7:0] py);
		send_req(CMD_SET, px, py, 8'($urandom), 8'($urandom), 11'($urandom), 8'($urandom));
	endtask

	task automatic write_reg(input logic idx, input logic [4:0] data);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Stop offering requests until every predicted draw is out and the block has settled.
	task automatic wait_for_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Result side: random stalls per result, and one long hold to back up the block.
	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (long_hold && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = no_idle ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Watchdog on cycles in which nothing moves.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wen) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("** bitmap_text_cursor_renderer_top: FAILED **");
				$finish;
			end
		end
	end

	// Request stimulus and verdict.
	initial begin
		int         stride;
		int         r;
		logic [7:0] alphabet [ALPHA_N];
		logic [7:0] pen;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Fill every byte the text characters can reach at any stride.
		// Width bytes for the reset stride stay mostly small.
		for (int a = 0; a < FILL_BYTES; a++) begin
			if (a % 6 == 0) begin
				load_byte(a, ($urandom_range(0, 7) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, 5)));
			end else begin
				load_byte(a, ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
					: 8'($urandom));
			end
		end
		for (int i = 0; i < ALPHA_N; i++) begin
			alphabet[i] = CH_FIRST + 8'(i);
		end

		// The last printable character's record at the reset stride, all reachable bytes.
		for (int k = 0; k < MAX_STRIDE; k++) begin
			load_byte((int'(CH_LAST) - int'(CH_FIRST)) * 6 + k,
				(k == 0) ? 8'($urandom_range(0, 5)) : 8'($urandom));
		end

		// Directed text: wide and empty glyphs, range edges, control characters, an unused command code.
		set_cursor(8'd255, 8'd250);
		load_byte((int'(CH_WIDE) - int'(CH_FIRST)) * 6, 8'hFF);
		load_byte((int'(CH_EMPTY) - int'(CH_FIRST)) * 6, 8'h00);
		put_char(CH_WIDE, 8'hFF);
		put_char(CH_EMPTY, 8'h00);
		put_char(CH_FIRST, 8'h3C);
		put_char(CH_LAST, 8'hC3);
		put_char(CH_FIRST - 8'd1, 8'h11);
		put_char(CH_LAST + 8'd1, 8'h22);
		put_char(8'hFF, 8'h33);
		put_char(8'h00, 8'h44);
		put_char(CH_BS, 8'h55);
		put_char(CH_WIDE, 8'h66);
		put_char(CH_BS, 8'h77);
		put_char(CH_LF, 8'h88);
		put_char(CH_BELL, 8'h99);
		put_char(CH_FF, 8'hAA);
		send_req(CMD_NONE, 8'($urandom), 8'($urandom), 8'($urandom), CH_FIRST, 11'($urandom),
			8'($urandom));
		set_cursor(8'd0, 8'd0);
		load_byte(GLYPH_MEM_DEPTH - 1, 8'hAA);
		put_char(CH_LAST, 8'h5A);

		// Random text over a range of register settings, each phase starting from idle.
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_for_idle();
			write_reg(REG_STRIDE, STRIDE_SET[ph]);
			write_reg(REG_HEIGHT, {1'($urandom), HEIGHT_SET[ph]});
			stride = (STRIDE_SET[ph] == 5'd0) ? 1 : ((int'(STRIDE_SET[ph]) > MAX_STRIDE)
				? MAX_STRIDE : int'(STRIDE_SET[ph]));
			no_idle = (ph % 3 == 2);

			// Widths that fit the record, with the odd wide one.
			for (int i = 0; i < ALPHA_N; i++) begin
				load_byte((int'(alphabet[i]) - int'(CH_FIRST)) * stride,
					($urandom_range(0, 9) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, stride - 1)));
			end
			if (ph == 3) begin
				long_hold = 1'b1;
			end

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				pen = 8'($urandom);
				if (r < 55) begin
					put_char(alphabet[$urandom_range(0, ALPHA_N - 1)], pen);
				end else if (r < 65) begin
					case ($urandom_range(0, 3))
						0: put_char(CH_BELL, pen);
						1: put_char(CH_BS, pen);
						2: put_char(CH_LF, pen);
						default: put_char(CH_FF, pen);
					endcase
				end else if (r < 70) begin
					// Codes outside the printable range.
					put_char(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
						: 8'($urandom_range(127, 255)), pen);
				end else if (r < 80) begin
					load_byte((int'(alphabet[$urandom_range(0, ALPHA_N - 1)]) - int'(CH_FIRST))
						* stride + $urandom_range(1, 15), 8'($urandom));
				end else if (r < 85) begin
					load_byte($urandom_range(0, GLYPH_MEM_DEPTH - 1), 8'($urandom));
				end else if (r < 93) begin
					set_cursor(8'($urandom), 8'($urandom));
				end else begin
					send_req(CMD_NONE, 8'($urandom), 8'($urandom), pen, 8'($urandom),
						11'($urandom), 8'($urandom));
				end
			end
		end

		wait_for_idle();
		if (fails == 0) begin
			$display("** bitmap_text_cursor_renderer_top: PASSED **");
		end else begin
			$display("** bitmap_text_cursor_renderer_top: FAILED **");
		end
		$finish;
	end

endmodule
